FILE: hdl/sfsd_pkg.sv
// shared types, constants and lookup functions of the status frame display decoder
package sfsd_pkg;

   // standby timer reload after reset
   localparam logic [15:0] STANDBY_RESET = 16'd5000;

   // result mode codes
   localparam logic [1:0] MODE_BLANK   = 2'd0;
   localparam logic [1:0] MODE_LIT     = 2'd1;
   localparam logic [1:0] MODE_READOUT = 2'd2;

   // unit mark codes
   localparam logic [1:0] MARKS_NONE = 2'd0;
   localparam logic [1:0] MARKS_F    = 2'd1;
   localparam logic [1:0] MARKS_C    = 2'd2;
   localparam logic [1:0] MARKS_BOTH = 2'd3;

   // all-lit pattern values
   localparam logic [4:0] BAR_FULL = 5'h1F;
   localparam logic [6:0] SEG_FULL = 7'h7F;

   // special message bytes
   localparam logic [7:0] BYTE_ALL_LIT = 8'hFF;
   localparam logic [7:0] BYTE_BLANK   = 8'h00;
   localparam logic [7:0] BYTE_COMMA   = 8'h2C;
   localparam logic [7:0] BYTE_ZERO    = 8'h30;
   localparam logic [7:0] BYTE_NINE    = 8'h39;
   localparam logic [7:0] BYTE_UNIT_C  = 8'h43;
   localparam logic [7:0] BYTE_UNIT_F  = 8'h46;

   // frame layout
   localparam logic [3:0] POS_MAX       = 4'd15;
   localparam logic [3:0] POS_HDR_END   = 4'd6;
   localparam logic [3:0] POS_FIELDS    = 4'd8;
   localparam logic [3:0] POS_MIN_LAST  = 4'd5;
   localparam logic [2:0] COMMA_MAX     = 3'd4;
   localparam logic [2:0] COMMA_TEMP    = 3'd1;

   // message kind picked by the first byte
   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_LIT     = 2'd1,
      CMD_BLANK   = 2'd2,
      CMD_READOUT = 2'd3
   } cmd_type;

   // display record handed from the parser to the formatter
   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  usage;
      logic [11:0] temp;
      logic [1:0]  marks;
   } rec_type;

   // formatted display fields
   typedef struct packed {
      logic [1:0] mode;
      logic [4:0] bar;
      logic [6:0] hundreds;
      logic [6:0] tens;
      logic [6:0] ones;
      logic [1:0] marks;
      logic       indicator;
   } disp_type;

   // expected header text
   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h48;
         3'd1:    c = 8'h4C;
         3'd2:    c = 8'h58;
         3'd3:    c = 8'h44;
         3'd4:    c = 8'h41;
         3'd5:    c = 8'h54;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // seven-segment code, nibble values above nine wrap to their decimal digit
   function automatic logic [6:0] seg_code(input logic [3:0] d);
      logic [6:0] s;
      case (d)
         4'd0, 4'd10: s = 7'h3F;
         4'd1, 4'd11: s = 7'h06;
         4'd2, 4'd12: s = 7'h5B;
         4'd3, 4'd13: s = 7'h4F;
         4'd4, 4'd14: s = 7'h66;
         4'd5, 4'd15: s = 7'h6D;
         4'd6:        s = 7'h7D;
         4'd7:        s = 7'h07;
         4'd8:        s = 7'h7F;
         default:     s = 7'h6F;
      endcase
      return s;
   endfunction

   // five-segment usage bar
   function automatic logic [4:0] bar_code(input logic [7:0] u);
      logic [4:0] b;
      if (u == 8'd0) begin
         b = 5'h00;
      end else if (u <= 8'd20) begin
         b = 5'h01;
      end else if (u <= 8'd40) begin
         b = 5'h03;
      end else if (u <= 8'd60) begin
         b = 5'h07;
      end else if (u <= 8'd80) begin
         b = 5'h0F;
      end else begin
         b = 5'h1F;
      end
      return b;
   endfunction

endpackage

FILE: hdl/sfsd_parser.sv
// frame parser, standby timer and display record register
module sfsd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               advance,
   input  logic               item_kind,
   input  logic [7:0]         item_byte,
   input  logic               item_last,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata,
   output logic               rec_valid,
   output sfsd_pkg::rec_type  rec
);

   logic [15:0]       ticks_ff, left_ff, left_in, left_dec;
   logic [3:0]        pos_ff, pos_in;
   logic              hdr_ff, hdr_in;
   sfsd_pkg::cmd_type cmd_ff, cmd_in;
   logic [2:0]        comma_ff, comma_in;
   logic              ended_ff, ended_in;
   logic [7:0]        usage_ff, usage_in, usage_mul;
   logic [11:0]       temp_ff, temp_in;
   logic [7:0]        unit_ff, unit_in;
   logic              taken_ff, taken_in;
   logic              is_digit;
   logic              emit;
   sfsd_pkg::rec_type rec_new;
   logic              rec_valid_ff;
   sfsd_pkg::rec_type rec_ff;

   assign left_dec  = left_ff - 16'd1;
   assign is_digit  = (item_byte >= sfsd_pkg::BYTE_ZERO) && (item_byte <= sfsd_pkg::BYTE_NINE);
   // usage * 10 + digit, wrapping at eight bits
   assign usage_mul = {usage_ff[4:0], 3'b000} + {usage_ff[6:0], 1'b0} + {4'd0, item_byte[3:0]};

   // next frame state and the record a transaction produces
   always_comb begin
      left_in  = left_ff;
      pos_in   = pos_ff;
      hdr_in   = hdr_ff;
      cmd_in   = cmd_ff;
      comma_in = comma_ff;
      ended_in = ended_ff;
      usage_in = usage_ff;
      temp_in  = temp_ff;
      unit_in  = unit_ff;
      taken_in = taken_ff;
      emit     = 1'b0;
      rec_new  = '{mode: sfsd_pkg::MODE_BLANK, usage: 8'd0, temp: 12'd0,
                   marks: sfsd_pkg::MARKS_NONE};
      if (item_kind) begin
         // millisecond tick
         if (left_dec == 16'd0) begin
            left_in = ticks_ff;
            emit    = 1'b1;
         end else begin
            left_in = left_dec;
         end
      end else begin
         // message byte
         pos_in = (pos_ff == sfsd_pkg::POS_MAX) ? pos_ff : pos_ff + 4'd1;
         if (pos_ff == 4'd0) begin
            if (item_byte == sfsd_pkg::BYTE_ALL_LIT) begin
               cmd_in = sfsd_pkg::CMD_LIT;
            end else if (item_byte == sfsd_pkg::BYTE_BLANK) begin
               cmd_in = sfsd_pkg::CMD_BLANK;
            end else begin
               cmd_in = sfsd_pkg::CMD_READOUT;
            end
         end
         if (cmd_in == sfsd_pkg::CMD_READOUT) begin
            if (pos_ff < sfsd_pkg::POS_HDR_END) begin
               if (item_byte != sfsd_pkg::hdr_char(pos_ff[2:0])) begin
                  hdr_in = 1'b0;
               end
            end else if (pos_ff >= sfsd_pkg::POS_FIELDS) begin
               if (item_byte == sfsd_pkg::BYTE_COMMA) begin
                  if (comma_ff < sfsd_pkg::COMMA_MAX) begin
                     comma_in = comma_ff + 3'd1;
                  end
                  ended_in = 1'b0;
               end else if (comma_ff >= sfsd_pkg::COMMA_MAX) begin
                  if (!taken_ff) begin
                     unit_in  = item_byte;
                     taken_in = 1'b1;
                  end
               end else if (comma_ff <= sfsd_pkg::COMMA_TEMP && !ended_ff) begin
                  if (is_digit) begin
                     if (comma_ff == 3'd0) begin
                        usage_in = usage_mul;
                     end else begin
                        temp_in = {temp_ff[7:0], item_byte[3:0]};
                     end
                  end else begin
                     ended_in = 1'b1;
                  end
               end
            end
         end
         // end of message: build the record and restart the parser
         if (item_last) begin
            unique case (cmd_in)
               sfsd_pkg::CMD_LIT: begin
                  emit         = 1'b1;
                  rec_new.mode = sfsd_pkg::MODE_LIT;
                  left_in      = ticks_ff;
               end
               sfsd_pkg::CMD_BLANK: begin
                  emit    = 1'b1;
                  left_in = ticks_ff;
               end
               sfsd_pkg::CMD_READOUT: begin
                  if (hdr_in && pos_ff >= sfsd_pkg::POS_MIN_LAST) begin
                     emit          = 1'b1;
                     rec_new.mode  = sfsd_pkg::MODE_READOUT;
                     rec_new.usage = usage_in;
                     rec_new.temp  = temp_in;
                     if (taken_in && unit_in == sfsd_pkg::BYTE_UNIT_C) begin
                        rec_new.marks = sfsd_pkg::MARKS_C;
                     end else if (taken_in && unit_in == sfsd_pkg::BYTE_UNIT_F) begin
                        rec_new.marks = sfsd_pkg::MARKS_F;
                     end
                     left_in = ticks_ff;
                  end
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
            pos_in   = 4'd0;
            hdr_in   = 1'b1;
            cmd_in   = sfsd_pkg::CMD_NONE;
            comma_in = 3'd0;
            ended_in = 1'b0;
            usage_in = 8'd0;
            temp_in  = 12'd0;
            unit_in  = 8'd0;
            taken_in = 1'b0;
         end
      end
   end

   // standby register
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= sfsd_pkg::STANDBY_RESET;
      end else if (csr_we) begin
         ticks_ff <= csr_wdata;
      end
   end

   // frame state and timer
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= sfsd_pkg::STANDBY_RESET;
         pos_ff   <= 4'd0;
         hdr_ff   <= 1'b1;
         cmd_ff   <= sfsd_pkg::CMD_NONE;
         comma_ff <= 3'd0;
         ended_ff <= 1'b0;
         usage_ff <= 8'd0;
         temp_ff  <= 12'd0;
         unit_ff  <= 8'd0;
         taken_ff <= 1'b0;
      end else if (accept) begin
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         hdr_ff   <= hdr_in;
         cmd_ff   <= cmd_in;
         comma_ff <= comma_in;
         ended_ff <= ended_in;
         usage_ff <= usage_in;
         temp_ff  <= temp_in;
         unit_ff  <= unit_in;
         taken_ff <= taken_in;
      end
   end

   // record stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
      end else if (accept) begin
         rec_valid_ff <= emit;
      end else if (advance) begin
         rec_valid_ff <= 1'b0;
      end
   end

   // record stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rec_ff <= rec_new;
      end
   end

   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

endmodule

FILE: hdl/sfsd_format.sv
// display formatter: bar pattern, segment codes with leading-zero blanking
module sfsd_format (
   input  sfsd_pkg::rec_type  rec,
   output sfsd_pkg::disp_type disp
);

   logic [3:0] h, t, o;

   assign h = rec.temp[11:8];
   assign t = rec.temp[7:4];
   assign o = rec.temp[3:0];

   // pick the display fields by mode
   always_comb begin
      disp = '{mode: sfsd_pkg::MODE_BLANK, bar: 5'd0, hundreds: 7'd0, tens: 7'd0,
               ones: 7'd0, marks: sfsd_pkg::MARKS_NONE, indicator: 1'b0};
      unique case (rec.mode)
         sfsd_pkg::MODE_LIT: begin
            disp.mode      = sfsd_pkg::MODE_LIT;
            disp.bar       = sfsd_pkg::BAR_FULL;
            disp.hundreds  = sfsd_pkg::SEG_FULL;
            disp.tens      = sfsd_pkg::SEG_FULL;
            disp.ones      = sfsd_pkg::SEG_FULL;
            disp.marks     = sfsd_pkg::MARKS_BOTH;
            disp.indicator = 1'b1;
         end
         sfsd_pkg::MODE_READOUT: begin
            disp.mode      = sfsd_pkg::MODE_READOUT;
            disp.bar       = sfsd_pkg::bar_code(rec.usage);
            disp.hundreds  = (h != 4'd0) ? sfsd_pkg::seg_code(h) : 7'd0;
            disp.tens      = (h != 4'd0 || t != 4'd0) ? sfsd_pkg::seg_code(t) : 7'd0;
            disp.ones      = sfsd_pkg::seg_code(o);
            disp.marks     = rec.marks;
            disp.indicator = 1'b1;
         end
         default: begin
            disp.mode = sfsd_pkg::MODE_BLANK;
         end
      endcase
   end

endmodule

FILE: hdl/status_frame_to_segment_display_unit.sv
// top level: status frame to segment display decoder with stream ports
// a result is registered in the record stage and then in the output register before it appears on rsp
// throughput: one transaction per cycle while req_tready is high; a full, stalled pipeline holds req
// a record stage and the output register buffer results; rsp backpressure stalls req only while both are full
// reset (synchronous, active high) clears the parser, loads the standby
// register and timer with 5000 and empties both stages
module status_frame_to_segment_display_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] kind
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [4:0] bar_segments, [11:5] hundreds_segments,
                                    // [18:12] tens_segments, [25:19] ones_segments,
                                    // [27:26] unit_marks, [28] indicator_on, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] mode
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic               accept;
   logic               advance;
   logic               rec_valid;
   sfsd_pkg::rec_type  rec;
   sfsd_pkg::disp_type disp;
   logic               out_valid_ff;
   sfsd_pkg::disp_type out_ff;

   // handshake
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !rec_valid || advance;
   assign accept     = req_tvalid && req_tready;

   sfsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .advance   (advance),
      .item_kind (req_tuser),
      .item_byte (req_tdata),
      .item_last (req_tlast),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   sfsd_format u_format (
      .rec  (rec),
      .disp (disp)
   );

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rec_valid;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= disp;
      end
   end

   // output packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.mode;
   assign rsp_tdata  = {3'd0, out_ff.indicator, out_ff.marks, out_ff.ones, out_ff.tens,
                        out_ff.hundreds, out_ff.bar};

   // a readout always has the indicator on
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sfsd_pkg::MODE_READOUT |-> rsp_tdata[28])
      else $error("readout transaction without indicator");

   // a blank result carries no lit segment
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sfsd_pkg::MODE_BLANK |-> rsp_tdata == 32'd0)
      else $error("blank transaction with lit segments");

   // with both stages full and stalled no transaction may enter
   assert property (@(posedge clock) disable iff (reset)
      rec_valid && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("transaction accepted into a full pipeline");

endmodule
